>>> hdl/allpass_stereo_widener_defines.svh
// ----------------------------------------------------------------------------
// allpass stereo widener assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ALLPASS_STEREO_WIDENER_DEFINES_SVH
`define ALLPASS_STEREO_WIDENER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication under reset
`define APSW_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apsw assertion failed");

// next-cycle implication under reset
`define APSW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apsw assertion failed");

`else

`define APSW_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define APSW_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/apsw_pkg.sv
// ----------------------------------------------------------------------------
// apsw_pkg
// types and fixed constants of the allpass stereo widener
// ----------------------------------------------------------------------------
package apsw_pkg;

    // gains are unsigned Q0.16 with one headroom bit
    localparam int GAIN_BITS = 17;
    localparam int GAIN_FRAC = 16;

    // 0.707 in Q0.16, rounded
    localparam int MID_SCALE = 46334;

    localparam logic [GAIN_BITS-1:0] PAN_GAIN_RESET  = 17'd46341;
    localparam logic [GAIN_BITS-1:0] SIDE_GAIN_RESET = 17'd65536;

    // register map
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_LEFT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_RIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIDE_GAIN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STAGE_ONE  = 3'd3;
    localparam int NUM_COEF_REGS = 3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_MUL  = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    typedef enum logic [4:0] {
        ST_MID   = 5'b00001,
        ST_STAGE = 5'b00010,
        ST_SIDE  = 5'b00100,
        ST_LEFT  = 5'b01000,
        ST_RIGHT = 5'b10000
    } t_step;

endpackage

>>> hdl/allpass_stereo_widener.sv
// per request: mid scale, each all-pass stage in turn, side gain, left and right pan
// ND = ceil(max(COEF_FRAC_BITS + 2, 18) / 2) radix-4 digits per multiply
// a new request is taken only when idle, after the last result has been handed over
// the shared two-lane digit-serial multiply-accumulate serves every step
// reset (synchronous, active low): gains and coefficients to defaults,
// all-pass histories to zero, no result pending
// ----------------------------------------------------------------------------
// allpass_stereo_widener
// mono in, stereo out: mid scale, cascaded all-pass side path, pan gains
// ----------------------------------------------------------------------------
`include "allpass_stereo_widener_defines.svh"

module allpass_stereo_widener #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 16,
    parameter int NUM_STAGES     = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [apsw_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [2*(COEF_FRAC_BITS+2)-1:0]       i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_in,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [SAMPLE_BITS-1:0]         o_left_out,
    output logic signed [SAMPLE_BITS-1:0]         o_right_out
);

    localparam int GB    = apsw_pkg::GAIN_BITS;
    localparam int GF    = apsw_pkg::GAIN_FRAC;
    localparam int SB    = SAMPLE_BITS;
    localparam int STB   = SAMPLE_BITS + 4;
    localparam int CB    = COEF_FRAC_BITS + 2;
    localparam int MBMIN = (CB > GB + 1) ? CB : GB + 1;
    localparam int MB    = MBMIN + (MBMIN % 2);
    localparam int ND    = MB / 2;
    localparam int CW    = $clog2(ND);
    localparam int DW    = STB + 1;
    localparam int AW    = DW + MB + 1;
    localparam int SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

    localparam logic signed [AW-1:0] HI_ST  = {{(AW-STB+1){1'b0}}, {(STB-1){1'b1}}};
    localparam logic signed [AW-1:0] LO_ST  = {{(AW-STB+1){1'b1}}, {(STB-1){1'b0}}};
    localparam logic signed [AW-1:0] HI_SMP = {{(AW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [AW-1:0] LO_SMP = {{(AW-SB+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic signed [AW-1:0] RND_F  =
        {{(AW-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    localparam logic signed [AW-1:0] RND_G  = {{(AW-GF){1'b0}}, 1'b1, {(GF-1){1'b0}}};

    // configuration
    logic [GB-1:0]        r_gain_left;
    logic [GB-1:0]        r_gain_right;
    logic [GB-1:0]        r_side_gain;
    logic signed [CB-1:0] r_a1 [NUM_STAGES];
    logic signed [CB-1:0] r_a2 [NUM_STAGES];

    // all-pass histories, z^-1 and z^-2 per stage
    logic signed [STB-1:0] r_xh0 [NUM_STAGES];
    logic signed [STB-1:0] r_xh1 [NUM_STAGES];
    logic signed [STB-1:0] r_yh0 [NUM_STAGES];
    logic signed [STB-1:0] r_yh1 [NUM_STAGES];

    // control
    apsw_pkg::t_state r_state;
    apsw_pkg::t_step  r_step;
    logic [SW-1:0]    r_stg;
    logic [CW-1:0]    r_cnt;
    logic             r_ovalid;

    // datapath
    logic signed [DW-1:0]  r_d1, r_d2;
    logic [MB-1:0]         r_m1, r_m2;
    logic signed [AW-1:0]  r_init;
    logic signed [AW-1:0]  r_acc;
    logic signed [STB-1:0] r_sig;
    logic signed [STB-1:0] r_mid;
    logic signed [SB-1:0]  r_left;
    logic signed [SB-1:0]  r_right;
    logic signed [SB-1:0]  r_left_out;
    logic signed [SB-1:0]  r_right_out;

    logic signed [DW-1:0]  n_d1, n_d2;
    logic [MB-1:0]         n_m1, n_m2;
    logic signed [AW-1:0]  n_init;
    logic signed [AW-1:0]  n_acc;
    logic signed [AW-1:0]  fin_sum;
    logic signed [AW-1:0]  fin_q;
    logic signed [STB-1:0] res_st;
    logic signed [SB-1:0]  res_smp;

    logic signed [CB-1:0]  sel_a1, sel_a2;
    logic signed [STB-1:0] sel_xh0, sel_xh1, sel_yh0, sel_yh1;
    logic                  top_digit;
    logic                  stage_last;
    logic                  out_load;

    // one radix-4 digit times the multiplicand, top digit weighted signed
    function automatic logic signed [AW-1:0] digit_term(
        input logic signed [DW-1:0] d,
        input logic [1:0]           dig,
        input logic                 top
    );
        logic signed [AW-1:0] dx;
        logic signed [AW-1:0] t;
        dx = AW'(d);
        t  = '0;
        if (dig[1]) begin
            t = top ? -(dx <<< 1) : (dx <<< 1);
        end
        if (dig[0]) begin
            t = t + dx;
        end
        return t;
    endfunction

    assign sel_a1  = r_a1[r_stg];
    assign sel_a2  = r_a2[r_stg];
    assign sel_xh0 = r_xh0[r_stg];
    assign sel_xh1 = r_xh1[r_stg];
    assign sel_yh0 = r_yh0[r_stg];
    assign sel_yh1 = r_yh1[r_stg];

    assign top_digit  = (r_cnt == CW'(ND - 1));
    assign stage_last = (r_stg == SW'(NUM_STAGES - 1));
    assign out_load   = (r_state == apsw_pkg::S_OUT) && (!r_ovalid || i_ready);

    assign o_ready     = (r_state == apsw_pkg::S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;

    // operands of the next multiply-accumulate
    always_comb begin
        n_d1   = '0;
        n_d2   = '0;
        n_m1   = '0;
        n_m2   = '0;
        n_init = RND_G;
        case (r_step)
            apsw_pkg::ST_MID: begin
                n_d1 = DW'(r_sig);
                n_m1 = MB'(apsw_pkg::MID_SCALE);
            end
            apsw_pkg::ST_STAGE: begin
                // a1*(x1 - y1) + a2*(x - y2) + x2
                n_d1   = DW'(sel_xh0) - DW'(sel_yh0);
                n_d2   = DW'(r_sig) - DW'(sel_yh1);
                n_m1   = MB'(sel_a1);
                n_m2   = MB'(sel_a2);
                n_init = (AW'(sel_xh1) <<< COEF_FRAC_BITS) + RND_F;
            end
            apsw_pkg::ST_SIDE: begin
                n_d1 = DW'(r_sig);
                n_m1 = MB'(r_side_gain);
            end
            apsw_pkg::ST_LEFT: begin
                n_d1 = DW'(r_mid) - DW'(r_sig);
                n_m1 = MB'(r_gain_left);
            end
            apsw_pkg::ST_RIGHT: begin
                n_d1 = DW'(r_mid) + DW'(r_sig);
                n_m1 = MB'(r_gain_right);
            end
            default: begin
                n_init = RND_G;
            end
        endcase
    end

    // msb-first horner step over both lanes
    always_comb begin
        n_acc = (r_acc <<< 2)
              + digit_term(r_d1, r_m1[MB-1 -: 2], top_digit)
              + digit_term(r_d2, r_m2[MB-1 -: 2], top_digit);
    end

    // round, rescale and saturate
    always_comb begin
        fin_sum = r_acc + r_init;
        if (r_step == apsw_pkg::ST_STAGE) begin
            fin_q = fin_sum >>> COEF_FRAC_BITS;
        end else begin
            fin_q = fin_sum >>> GF;
        end
        if (fin_q > HI_ST) begin
            res_st = HI_ST[STB-1:0];
        end else if (fin_q < LO_ST) begin
            res_st = LO_ST[STB-1:0];
        end else begin
            res_st = fin_q[STB-1:0];
        end
        if (fin_q > HI_SMP) begin
            res_smp = HI_SMP[SB-1:0];
        end else if (fin_q < LO_SMP) begin
            res_smp = LO_SMP[SB-1:0];
        end else begin
            res_smp = fin_q[SB-1:0];
        end
    end

    // control, configuration and histories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= apsw_pkg::S_IDLE;
            r_step       <= apsw_pkg::ST_MID;
            r_stg        <= '0;
            r_cnt        <= '0;
            r_ovalid     <= 1'b0;
            r_gain_left  <= apsw_pkg::PAN_GAIN_RESET;
            r_gain_right <= apsw_pkg::PAN_GAIN_RESET;
            r_side_gain  <= apsw_pkg::SIDE_GAIN_RESET;
            for (int k = 0; k < NUM_STAGES; k++) begin
                r_a1[k]  <= '0;
                r_a2[k]  <= '0;
                r_xh0[k] <= '0;
                r_xh1[k] <= '0;
                r_yh0[k] <= '0;
                r_yh1[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    apsw_pkg::REG_GAIN_LEFT:  r_gain_left  <= i_cfg_data[GB-1:0];
                    apsw_pkg::REG_GAIN_RIGHT: r_gain_right <= i_cfg_data[GB-1:0];
                    apsw_pkg::REG_SIDE_GAIN:  r_side_gain  <= i_cfg_data[GB-1:0];
                    default: begin
                    end
                endcase
                // stages past the third have no register and keep zero
                for (int k = 0; k < NUM_STAGES; k++) begin
                    if (k < apsw_pkg::NUM_COEF_REGS &&
                        i_cfg_idx == apsw_pkg::REG_STAGE_ONE
                                     + apsw_pkg::CFG_IDX_BITS'(k)) begin
                        r_a1[k] <= i_cfg_data[CB-1:0];
                        r_a2[k] <= i_cfg_data[2*CB-1:CB];
                    end
                end
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                apsw_pkg::S_IDLE: begin
                    if (i_valid) begin
                        r_step  <= apsw_pkg::ST_MID;
                        r_state <= apsw_pkg::S_LOAD;
                    end
                end
                apsw_pkg::S_LOAD: begin
                    r_cnt   <= CW'(ND - 1);
                    r_state <= apsw_pkg::S_MUL;
                end
                apsw_pkg::S_MUL: begin
                    if (r_cnt == '0) begin
                        r_state <= apsw_pkg::S_FIN;
                    end else begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                apsw_pkg::S_FIN: begin
                    r_state <= apsw_pkg::S_LOAD;
                    case (r_step)
                        apsw_pkg::ST_MID: begin
                            r_stg  <= '0;
                            r_step <= apsw_pkg::ST_STAGE;
                        end
                        apsw_pkg::ST_STAGE: begin
                            r_xh1[r_stg] <= sel_xh0;
                            r_xh0[r_stg] <= r_sig;
                            r_yh1[r_stg] <= sel_yh0;
                            r_yh0[r_stg] <= res_st;
                            if (stage_last) begin
                                r_stg  <= '0;
                                r_step <= apsw_pkg::ST_SIDE;
                            end else begin
                                r_stg <= r_stg + SW'(1);
                            end
                        end
                        apsw_pkg::ST_SIDE:  r_step <= apsw_pkg::ST_LEFT;
                        apsw_pkg::ST_LEFT:  r_step <= apsw_pkg::ST_RIGHT;
                        apsw_pkg::ST_RIGHT: r_state <= apsw_pkg::S_OUT;
                        default:            r_state <= apsw_pkg::S_IDLE;
                    endcase
                end
                apsw_pkg::S_OUT: begin
                    if (out_load) begin
                        r_state <= apsw_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= apsw_pkg::S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            apsw_pkg::S_IDLE: begin
                if (i_valid) begin
                    r_sig <= STB'(i_sample_in);
                end
            end
            apsw_pkg::S_LOAD: begin
                r_d1   <= n_d1;
                r_d2   <= n_d2;
                r_m1   <= n_m1;
                r_m2   <= n_m2;
                r_init <= n_init;
                r_acc  <= '0;
            end
            apsw_pkg::S_MUL: begin
                r_acc <= n_acc;
                r_m1  <= r_m1 << 2;
                r_m2  <= r_m2 << 2;
            end
            apsw_pkg::S_FIN: begin
                case (r_step)
                    apsw_pkg::ST_MID: begin
                        r_mid <= res_st;
                        r_sig <= res_st;
                    end
                    apsw_pkg::ST_STAGE: r_sig   <= res_st;
                    apsw_pkg::ST_SIDE:  r_sig   <= res_st;
                    apsw_pkg::ST_LEFT:  r_left  <= res_smp;
                    apsw_pkg::ST_RIGHT: r_right <= res_smp;
                    default: begin
                    end
                endcase
            end
            apsw_pkg::S_OUT: begin
                if (out_load) begin
                    r_left_out  <= r_left;
                    r_right_out <= r_right;
                end
            end
            default: begin
            end
        endcase
    end

    `APSW_ASSERT_NEXT(a_request_starts_load, i_clk, i_rst_n, i_valid && o_ready, r_state == apsw_pkg::S_LOAD)
    `APSW_ASSERT_IMP(a_digit_count_range, i_clk, i_rst_n, r_state == apsw_pkg::S_MUL, r_cnt <= CW'(ND - 1))
    `APSW_ASSERT_IMP(a_stage_index_range, i_clk, i_rst_n, r_step == apsw_pkg::ST_STAGE, r_stg <= SW'(NUM_STAGES - 1))
    `APSW_ASSERT_NEXT(a_result_posted, i_clk, i_rst_n, out_load, o_valid && r_state == apsw_pkg::S_IDLE)

endmodule
